// ===== hdl/swec_pkg.sv =====
// Shared types and constants for the sliding window event counter.
`timescale 1ns / 1ps

package swec_pkg;

  localparam int unsigned StoreDepthDef = 64;
  localparam int unsigned StampW        = 32;
  localparam int unsigned WindowW       = 31;
  localparam int unsigned CountW        = 7;
  localparam int unsigned ApbAddrW      = 3;
  localparam int unsigned ApbDataW      = 32;

  localparam logic [WindowW-1:0] WindowRst = WindowW'(1000);

  // register index, taken from paddr above the byte offset
  localparam logic RegWindow = 1'b0;

  // item classes
  localparam logic ModeEvent = 1'b0;
  localparam logic ModeQuery = 1'b1;

  typedef struct packed {
    logic              is_query;
    logic [StampW-1:0] stamp;
  } cmd_t;

  typedef enum logic {
    BkIdle,
    BkCheck
  } bk_state_e;

endpackage

// ===== hdl/swec_if.sv =====
// Handshake channels for input items and result items.
`timescale 1ns / 1ps

interface swec_req_if
  import swec_pkg::*;
;
  logic              valid;
  logic              ready;
  logic              mode;
  logic [StampW-1:0] now_stamp;

  modport source (output valid, output mode, output now_stamp, input ready);
  modport sink   (input valid, input mode, input now_stamp, output ready);
endinterface

interface swec_rsp_if
  import swec_pkg::*;
;
  logic              valid;
  logic              ready;
  logic [CountW-1:0] event_count;
  logic              overflowed;

  modport source (output valid, output event_count, output overflowed, input ready);
  modport sink   (input valid, input event_count, input overflowed, output ready);
endinterface

// ===== hdl/swec_front.sv =====
// Front end: accepts items, classifies them and holds them in a two-entry queue.
`timescale 1ns / 1ps

module swec_front
  import swec_pkg::*;
(
  input  logic       clk_i,
  input  logic       rst_ni,
  swec_req_if.sink   req_i,
  output logic       cmd_valid_o,
  output cmd_t       cmd_o,
  input  logic       cmd_ready_i
);

  cmd_t       ent_q [2];
  logic       wr_ptr_q, rd_ptr_q;
  logic [1:0] cnt_q;
  logic       push, pop;
  cmd_t       cmd_in;

  assign req_i.ready = (cnt_q != 2'd2);
  assign push        = req_i.valid && req_i.ready;
  assign pop         = cmd_valid_o && cmd_ready_i;
  assign cmd_valid_o = (cnt_q != 2'd0);
  assign cmd_o       = ent_q[rd_ptr_q];

  always_comb begin
    cmd_in.is_query = (req_i.mode == ModeQuery);
    cmd_in.stamp    = req_i.now_stamp;
  end

  always_ff @(posedge clk_i) begin
    if (push) begin
      ent_q[wr_ptr_q] <= cmd_in;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= 1'b0;
      rd_ptr_q <= 1'b0;
      cnt_q    <= 2'd0;
    end else begin
      if (push) wr_ptr_q <= ~wr_ptr_q;
      if (pop)  rd_ptr_q <= ~rd_ptr_q;
      case ({push, pop})
        2'b10:   cnt_q <= cnt_q + 2'd1;
        2'b01:   cnt_q <= cnt_q - 2'd1;
        default: cnt_q <= cnt_q;
      endcase
    end
  end

endmodule

// ===== hdl/swec_back.sv =====
// Back end: stamp ring in memory, expiry walk for queries and the result register.
`timescale 1ns / 1ps

module swec_back
  import swec_pkg::*;
#(
  parameter int unsigned StoreDepth = StoreDepthDef
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               cmd_valid_i,
  input  cmd_t               cmd_i,
  output logic               cmd_ready_o,
  input  logic [WindowW-1:0] window_i,
  swec_rsp_if.source         rsp_o
);

  localparam int unsigned PtrW  = (StoreDepth > 1) ? $clog2(StoreDepth) : 1;
  localparam int unsigned FillW = $clog2(StoreDepth + 1);

  localparam logic [PtrW-1:0]  PtrLast = PtrW'(StoreDepth - 1);
  localparam logic [FillW-1:0] FillMax = FillW'(StoreDepth);

  function automatic logic [PtrW-1:0] ring_next(input logic [PtrW-1:0] p);
    return (p == PtrLast) ? '0 : p + 1'b1;
  endfunction

  logic [StampW-1:0] mem [StoreDepth];
  logic [StampW-1:0] rd_q;

  bk_state_e         state_q, state_d;
  logic [PtrW-1:0]   oldest_q, oldest_d, newest_q, newest_d;
  logic [FillW-1:0]  fill_q, fill_d;
  logic              lost_q, lost_d;
  logic [StampW-1:0] now_q, now_d;
  logic              wr_en;
  logic              out_load, out_free;
  logic              out_valid_q;
  logic [CountW-1:0] count_q;
  logic              ovf_q;
  logic [StampW-1:0] age;
  logic              expire;

  assign age      = now_q - rd_q;
  assign expire   = (fill_q != '0) && (age > {1'b0, window_i});
  assign out_free = !out_valid_q || rsp_o.ready;

  always_comb begin
    state_d     = state_q;
    oldest_d    = oldest_q;
    newest_d    = newest_q;
    fill_d      = fill_q;
    lost_d      = lost_q;
    now_d       = now_q;
    wr_en       = 1'b0;
    out_load    = 1'b0;
    cmd_ready_o = 1'b0;
    case (state_q)
      BkIdle: begin
        cmd_ready_o = 1'b1;
        if (cmd_valid_i) begin
          if (!cmd_i.is_query) begin
            if (fill_q == FillMax) begin
              lost_d = 1'b1;
            end else begin
              wr_en    = 1'b1;
              newest_d = ring_next(newest_q);
              fill_d   = fill_q + 1'b1;
            end
          end else begin
            // oldest stamp is read at this edge, checked next cycle
            now_d   = cmd_i.stamp;
            state_d = BkCheck;
          end
        end
      end
      BkCheck: begin
        if (expire) begin
          oldest_d = ring_next(oldest_q);
          fill_d   = fill_q - 1'b1;
        end else if (out_free) begin
          out_load = 1'b1;
          state_d  = BkIdle;
        end
      end
      default: state_d = BkIdle;
    endcase
  end

  // read follows the next oldest pointer so the stamp under test is always ready
  always_ff @(posedge clk_i) begin
    if (wr_en) begin
      mem[newest_q] <= cmd_i.stamp;
    end
    rd_q <= mem[oldest_d];
  end

  always_ff @(posedge clk_i) begin
    now_q <= now_d;
    if (out_load) begin
      count_q <= CountW'(fill_q);
      ovf_q   <= lost_q;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= BkIdle;
      oldest_q    <= '0;
      newest_q    <= '0;
      fill_q      <= '0;
      lost_q      <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      state_q  <= state_d;
      oldest_q <= oldest_d;
      newest_q <= newest_d;
      fill_q   <= fill_d;
      lost_q   <= lost_d;
      if (out_load) begin
        out_valid_q <= 1'b1;
      end else if (rsp_o.ready) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  assign rsp_o.valid       = out_valid_q;
  assign rsp_o.event_count = count_q;
  assign rsp_o.overflowed  = ovf_q;

endmodule

// ===== hdl/sliding_window_event_counter.sv =====
// Top level of the sliding window event counter: APB register, front and back ends.
// Counts events inside a sliding time window. Each input transaction is an event
// (mode 0) or a query (mode 1) carrying the current 32-bit timestamp. Events are
// stored in a ring of StoreDepth stamps; an event that finds the ring full is
// dropped and sets a sticky overflow flag. A query retires stamps from the oldest
// end whose modular age exceeds window_length (APB offset 0, reset 1000) and
// returns the remaining count plus the overflow flag. A two-entry queue sits
// between the input and the engine. The engine accepts a new item only while idle; a
// query holds it busy while it retires expired stamps one at a time, since the ring
// memory yields one stamp per cycle through its registered read port. No clearing
// pass is needed after reset. Configure only while the block is idle.
`timescale 1ns / 1ps

module sliding_window_event_counter
  import swec_pkg::*;
#(
  parameter int unsigned StoreDepth = StoreDepthDef
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  swec_req_if.sink            req_i,
  swec_rsp_if.source          rsp_o,
  input  logic                psel,
  input  logic                penable,
  input  logic                pwrite,
  input  logic [ApbAddrW-1:0] paddr,
  input  logic [ApbDataW-1:0] pwdata,
  output logic [ApbDataW-1:0] prdata,
  output logic                pready
);

  logic               window_sel;
  logic               cfg_wr;
  logic [WindowW-1:0] window_q;
  logic               cmd_valid, cmd_ready;
  cmd_t               cmd;

  assign pready     = 1'b1;
  assign window_sel = (paddr[ApbAddrW-1] == RegWindow);
  assign cfg_wr     = psel && penable && pwrite && pready && window_sel;
  assign prdata     = window_sel ? {1'b0, window_q} : '0;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      window_q <= WindowRst;
    end else if (cfg_wr) begin
      window_q <= pwdata[WindowW-1:0];
    end
  end

  swec_front u_front (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .req_i       (req_i),
    .cmd_valid_o (cmd_valid),
    .cmd_o       (cmd),
    .cmd_ready_i (cmd_ready)
  );

  swec_back #(
    .StoreDepth (StoreDepth)
  ) u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cmd_valid_i (cmd_valid),
    .cmd_i       (cmd),
    .cmd_ready_o (cmd_ready),
    .window_i    (window_q),
    .rsp_o       (rsp_o)
  );

endmodule

// ===== bench/swec_checker.sv =====
// Checker for the sliding window event counter: predicts query results and compares them.
`timescale 1ns / 1ps

module swec_checker
  import swec_pkg::*;
#(
  parameter int unsigned Depth = StoreDepthDef
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  swec_req_if                 req_mon,
  swec_rsp_if                 rsp_mon,
  input  logic                psel,
  input  logic                penable,
  input  logic                pwrite,
  input  logic [ApbAddrW-1:0] paddr,
  input  logic [ApbDataW-1:0] pwdata,
  input  logic                pready,
  output int unsigned         mismatch_cnt,
  output int unsigned         pending_cnt,
  output int unsigned         checked_cnt,
  output logic                overflow_seen
);

  typedef struct packed {
    logic [CountW-1:0] count;
    logic              ovf;
  } tally_t;

  logic [StampW-1:0]  ring [Depth];
  int unsigned        head;
  int unsigned        tail;
  int unsigned        fill;
  logic               lost;
  logic [WindowW-1:0] window;
  tally_t             expected_tally_q [$];
  int unsigned        errs;
  int unsigned        checked;

  task automatic record_stamp(input logic [StampW-1:0] stamp);
    if (fill >= Depth) begin
      lost = 1'b1;
    end else begin
      ring[tail] = stamp;
      tail = (tail + 1 == Depth) ? 0 : tail + 1;
      fill++;
    end
  endtask

  // retire stamps older than the window, oldest first; stop at the first one still inside
  function automatic tally_t expire_and_count(input logic [StampW-1:0] now);
    tally_t t;
    while (fill > 0 && (now - ring[head]) > {1'b0, window}) begin
      head = (head + 1 == Depth) ? 0 : head + 1;
      fill--;
    end
    t.count = CountW'(fill);
    t.ovf   = lost;
    return t;
  endfunction

  task automatic report(input string what, input tally_t exp_t);
    errs++;
    if (errs <= 10) begin
      $display("[%0t] %s: expected count=%0d ovf=%0b, got count=%0d ovf=%0b", $realtime,
               what, exp_t.count, exp_t.ovf, rsp_mon.event_count, rsp_mon.overflowed);
    end
  endtask

  initial begin
    errs    = 0;
    checked = 0;
    head    = 0;
    tail    = 0;
    fill    = 0;
    lost    = 1'b0;
    window  = WindowRst;
    mismatch_cnt  = 0;
    pending_cnt   = 0;
    checked_cnt   = 0;
    overflow_seen = 1'b0;
  end

  always @(posedge clk_i) begin
    tally_t exp_t;
    if (!rst_ni) begin
      head   = 0;
      tail   = 0;
      fill   = 0;
      lost   = 1'b0;
      window = WindowRst;
      expected_tally_q.delete();
    end else begin
      if (psel && penable && pwrite && pready && paddr[ApbAddrW-1:2] == RegWindow) begin
        window = pwdata[WindowW-1:0];
      end
      if (req_mon.valid && req_mon.ready) begin
        if (req_mon.mode == ModeEvent) begin
          record_stamp(req_mon.now_stamp);
        end else begin
          expected_tally_q.push_back(expire_and_count(req_mon.now_stamp));
        end
      end
      if (rsp_mon.valid && rsp_mon.ready) begin
        if (expected_tally_q.size() == 0) begin
          report("unexpected result", '0);
        end else begin
          exp_t = expected_tally_q.pop_front();
          checked++;
          if (rsp_mon.event_count !== exp_t.count || rsp_mon.overflowed !== exp_t.ovf) begin
            report("result mismatch", exp_t);
          end
        end
      end
    end
    mismatch_cnt  <= errs;
    pending_cnt   <= expected_tally_q.size();
    checked_cnt   <= checked;
    overflow_seen <= lost;
  end

endmodule

// ===== bench/tb_sliding_window_event_counter.sv =====
// Testbench top for the sliding window event counter: stimulus, idling and verdict.
`timescale 1ns / 1ps

module tb_sliding_window_event_counter;
  import swec_pkg::*;

  localparam int unsigned CycleLimit    = 400000;
  localparam int unsigned DrainCycles   = 16;
  localparam int unsigned ItemsPerPhase = 135;
  localparam int unsigned BurstLen      = 70;
  localparam int unsigned RegBeyond     = 1;

  logic clk   = 1'b0;
  logic rst_n = 1'b0;

  always #4 clk = ~clk;

  logic                psel;
  logic                penable;
  logic                pwrite;
  logic [ApbAddrW-1:0] paddr;
  logic [ApbDataW-1:0] pwdata;
  logic [ApbDataW-1:0] prdata;
  logic                pready;

  swec_req_if req_ch ();
  swec_rsp_if rsp_ch ();

  int unsigned mismatch_cnt;
  int unsigned pending_cnt;
  int unsigned checked_cnt;
  logic        overflow_seen;

  int unsigned        send_idle_pct = 0;
  int unsigned        recv_idle_pct = 0;
  int unsigned        n_events      = 0;
  int unsigned        n_queries     = 0;
  int unsigned        n_settings    = 0;
  logic [WindowW-1:0] window_now    = WindowRst;
  logic [StampW-1:0]  now_ts;

  sliding_window_event_counter dut (
    .clk_i   (clk),
    .rst_ni  (rst_n),
    .req_i   (req_ch),
    .rsp_o   (rsp_ch),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready)
  );

  swec_checker swec_chk (
    .clk_i         (clk),
    .rst_ni        (rst_n),
    .req_mon       (req_ch),
    .rsp_mon       (rsp_ch),
    .psel          (psel),
    .penable       (penable),
    .pwrite        (pwrite),
    .paddr         (paddr),
    .pwdata        (pwdata),
    .pready        (pready),
    .mismatch_cnt  (mismatch_cnt),
    .pending_cnt   (pending_cnt),
    .checked_cnt   (checked_cnt),
    .overflow_seen (overflow_seen)
  );

  initial rsp_ch.ready = 1'b0;

  always @(posedge clk) begin
    rsp_ch.ready <= ($urandom_range(0, 99) >= recv_idle_pct);
  end

  initial begin
    repeat (CycleLimit) @(posedge clk);
    $display("DONE: errors detected");
    $finish;
  end

  // called at a rising edge; returns at the edge where the transaction is taken
  task automatic send_item(input logic mode, input logic [StampW-1:0] stamp);
    while ($urandom_range(0, 99) < send_idle_pct) begin
      req_ch.valid <= 1'b0;
      @(posedge clk);
    end
    req_ch.valid     <= 1'b1;
    req_ch.mode      <= mode;
    req_ch.now_stamp <= stamp;
    do @(posedge clk); while (!(req_ch.valid && req_ch.ready));
    if (mode == ModeEvent) n_events++;
    else n_queries++;
  endtask

  task automatic drain();
    req_ch.valid <= 1'b0;
    @(posedge clk);
    while (pending_cnt != 0) @(posedge clk);
    repeat (DrainCycles) @(posedge clk);
  endtask

  task automatic apb_write(input int unsigned idx, input logic [ApbDataW-1:0] data);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= ApbAddrW'(idx << 2);
    pwdata  <= data;
    @(posedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
  endtask

  task automatic set_window(input logic [WindowW-1:0] w);
    apb_write(int'(RegWindow), {1'b0, w});
    window_now = w;
    n_settings++;
  endtask

  function automatic logic [WindowW-1:0] pick_window();
    logic [WindowW-1:0] w;
    case ($urandom_range(0, 5))
      0: w = '0;
      1: w = '1;
      2: w = WindowW'($urandom_range(1, 20));
      3: w = WindowW'($urandom_range(50, 500));
      4: w = WindowRst;
      default: w = WindowW'($urandom());
    endcase
    return w;
  endfunction

  task automatic run_segment(input int unsigned n_items, input bit with_burst);
    logic [StampW-1:0] step_max;
    int unsigned       r;
    step_max = ({1'b0, window_now} >> 3) + 3;
    for (int unsigned k = 0; k < n_items; k++) begin
      // fill the ring past capacity with stamps that all stay inside the window
      if (with_burst && k == n_items / 2) begin
        repeat (BurstLen) send_item(ModeEvent, now_ts);
        send_item(ModeQuery, now_ts);
      end
      r = $urandom_range(0, 99);
      if (r < 5) begin
        send_item(logic'($urandom_range(0, 1)), $urandom());
      end else begin
        now_ts += $urandom_range(0, step_max);
        send_item((r < 60) ? ModeEvent : ModeQuery, now_ts);
      end
    end
    send_item(ModeQuery, now_ts);
  endtask

  task automatic run_phase(input int unsigned snd_pct, input int unsigned rcv_pct);
    int unsigned budget;
    int unsigned n;
    int unsigned seg;
    send_idle_pct = snd_pct;
    recv_idle_pct = rcv_pct;
    budget = ItemsPerPhase;
    seg    = 0;
    while (budget > 0) begin
      drain();
      set_window(pick_window());
      n = $urandom_range(30, 70);
      if (n > budget) n = budget;
      run_segment(n, seg == 1);
      budget -= n;
      seg++;
    end
  endtask

  initial begin
    req_ch.valid     <= 1'b0;
    req_ch.mode      <= ModeEvent;
    req_ch.now_stamp <= '0;
    psel             <= 1'b0;
    penable          <= 1'b0;
    pwrite           <= 1'b0;
    paddr            <= '0;
    pwdata           <= '0;
    repeat (4) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // empty ring, then stamps straddling the 32-bit wrap under the reset window
    send_item(ModeQuery, 32'h0000_0000);
    send_item(ModeEvent, 32'hFFFF_FF00);
    send_item(ModeEvent, 32'hFFFF_FFF0);
    send_item(ModeQuery, 32'h0000_0050);
    send_item(ModeQuery, 32'h0000_02E8);  // age equals the window: kept
    send_item(ModeQuery, 32'h0000_02E9);
    drain();

    set_window('0);
    send_item(ModeEvent, 32'h1234_5678);
    send_item(ModeQuery, 32'h1234_5678);
    send_item(ModeQuery, 32'h1234_5679);
    drain();

    set_window('1);
    send_item(ModeEvent, 32'h0000_0000);
    send_item(ModeQuery, 32'h7FFF_FFFF);
    send_item(ModeQuery, 32'h8000_0000);
    drain();

    // write to an unmapped register must leave the window alone
    set_window(WindowW'(100));
    apb_write(RegBeyond, 32'hFFFF_FFFF);
    // out-of-order stamps: only the oldest is tested
    send_item(ModeEvent, 32'd1000);
    send_item(ModeEvent, 32'd10);
    send_item(ModeQuery, 32'd1050);
    send_item(ModeQuery, 32'd1101);
    send_item(ModeEvent, 32'hAAAA_AAAA);
    send_item(ModeEvent, 32'h5555_5555);
    send_item(ModeQuery, 32'h5555_5555);
    drain();

    now_ts = $urandom();
    run_phase(31, 68);
    run_phase(68, 31);
    run_phase(0, 0);
    drain();

    $display("Sent %0d events and %0d queries over %0d window settings; %0d results compared.",
             n_events, n_queries, n_settings, checked_cnt);
    $display("Ring overflow path %s.", overflow_seen ? "was reached" : "was not reached");
    if (mismatch_cnt == 0 && pending_cnt == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("DONE: errors detected");
    end
    $finish;
  end

endmodule

// ===== sliding_window_event_counter.f =====
hdl/swec_pkg.sv
hdl/swec_if.sv
hdl/swec_front.sv
hdl/swec_back.sv
hdl/sliding_window_event_counter.sv
bench/swec_checker.sv
bench/tb_sliding_window_event_counter.sv
